### src/plcc_pkg.sv
// Package for the polygon limit check and clamp unit.
// Holds the word types, the function codes, the controller states and the
// command and status bundles. Depends on nothing.
package plcc_pkg;

    localparam int C_COORD_W = 16;
    localparam int C_INDEX_W = 6;
    localparam int C_COUNT_W = 7;

    localparam logic C_FUNC_LOAD = 1'b0;
    localparam logic C_FUNC_TEST = 1'b1;

    // Drain length after the last vertex read, as a last counter value.
    localparam logic [1:0] C_DRAIN_LAST = 2'd2;

    typedef struct packed {
        logic                        func;
        logic [C_INDEX_W-1:0]        vertex_index;
        logic signed [C_COORD_W-1:0] coord_x;
        logic signed [C_COORD_W-1:0] coord_y;
    } t_in_word;

    typedef struct packed {
        logic                        feasible;
        logic signed [C_COORD_W-1:0] out_x;
        logic signed [C_COORD_W-1:0] out_y;
        logic [C_INDEX_W-1:0]        nearest_index;
    } t_out_word;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic start;
        logic wr_en;
        logic rd_en;
        logic rd_lead;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_stat;

endpackage

### src/polygon_limit_check_clamp_unit.sv
// Top level of the polygon limit check and clamp unit.
// Joins the controller and the datapath; depends on plcc_pkg, plcc_ctrl
// and plcc_datapath.
//
//  Channel | Direction | Handshake                 | Word
//  --------+-----------+---------------------------+---------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_in  (t_in_word)
//  out     | output    | o_out_valid / i_out_ready | o_out (t_out_word)
//  cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_data (vertex_count)
//
// A load word writes one vertex into the vertex memory. A test word with n
// vertices in use makes n + 1 reads of the single vertex memory port (the last
// vertex first, to open the closing edge), then passes three pipeline stages
// before its result is loaded into the output register. An empty polygon skips
// the reads and goes straight to loading the output register.
// Reset is synchronous and active low; it clears the controller, the
// vertex_count register and the valid flags, not the vertex memory.
// A finished result waits in the output register while the next word is
// taken; a test that ends while that register is still full holds there.
module polygon_limit_check_clamp_unit import plcc_pkg::*; #(
    parameter int MAX_VERTICES = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_word             i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_word            o_out,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [C_COUNT_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int NW = $clog2(MAX_VERTICES + 1);

    t_dp_cmd       cmd;
    t_dp_stat      stat;
    logic [AW-1:0] rd_addr;

    // The controller sequences one test at a time over the vertex memory.
    plcc_ctrl #(
        .MAX_VERTICES (MAX_VERTICES),
        .AW           (AW),
        .NW           (NW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_func   (i_in.func),
        .o_in_ready  (o_in_ready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_rd_addr   (rd_addr)
    );

    // The datapath walks the edges for parity and the vertices for the
    // nearest one in the same pass.
    plcc_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .AW           (AW)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_rd_addr   (rd_addr),
        .i_in        (i_in),
        .i_out_ready (i_out_ready),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

`ifndef ASSERT_OFF
    // A result is only loaded when the output register can take it.
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> (!o_out_valid || i_out_ready))
        else $error("result loaded into a full output register");

    // A loaded result is shown in the next cycle.
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |=> o_out_valid)
        else $error("loaded result not shown");

    // A test starts only on an accepted word.
    a_start_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.start |-> (i_in_valid && o_in_ready))
        else $error("test started without an accepted word");

    // The memory is never written while a test reads it.
    a_no_wr_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.wr_en && cmd.rd_en))
        else $error("vertex write during a test walk");
`endif

endmodule

### src/plcc_ctrl.sv
// Controller of the polygon limit check and clamp unit: the state machine,
// the vertex_count register and the vertex read sequencer.
// Depends on plcc_pkg.
module plcc_ctrl import plcc_pkg::*; #(
    parameter int MAX_VERTICES = 64,
    parameter int AW           = 6,
    parameter int NW           = 7
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_func,
    output logic                 o_in_ready,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [C_COUNT_W-1:0] i_cfg_data,
    input  t_dp_stat             i_stat,
    output t_dp_cmd              o_cmd,
    output logic [AW-1:0]        o_rd_addr
);

    t_state               r_state, n_state;
    logic [C_COUNT_W-1:0] r_vcount;
    logic [NW-1:0]        r_rd_cnt;
    logic [1:0]           r_drain_cnt;
    logic [NW-1:0]        n_eff;
    logic                 in_acc;

    // Counts above the store depth use the whole store.
    assign n_eff  = (int'(r_vcount) > MAX_VERTICES) ? NW'(MAX_VERTICES) : NW'(r_vcount);
    assign in_acc = i_in_valid && (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && (i_in_func == C_FUNC_TEST)) begin
                    n_state = (n_eff == '0) ? ST_FINISH : ST_WALK;
                end
            end
            ST_WALK: begin
                if (r_rd_cnt == n_eff) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (r_drain_cnt == C_DRAIN_LAST) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready       = (r_state == ST_IDLE);
        o_cfg_ready      = 1'b1;
        o_cmd.start      = in_acc && (i_in_func == C_FUNC_TEST);
        o_cmd.wr_en      = in_acc && (i_in_func == C_FUNC_LOAD);
        o_cmd.rd_en      = (r_state == ST_WALK);
        o_cmd.rd_lead    = (r_rd_cnt == '0);
        o_cmd.load_out   = (r_state == ST_FINISH) && i_stat.out_free;
        // The first read fetches the last vertex, the closing edge's start.
        if (r_rd_cnt == '0) begin
            o_rd_addr = AW'(n_eff - NW'(1));
        end else begin
            o_rd_addr = AW'(r_rd_cnt - NW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_vcount    <= '0;
            r_rd_cnt    <= '0;
            r_drain_cnt <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_vcount <= i_cfg_data;
            end
            if (r_state == ST_WALK) begin
                r_rd_cnt <= r_rd_cnt + NW'(1);
            end else begin
                r_rd_cnt <= '0;
            end
            if (r_state == ST_DRAIN) begin
                r_drain_cnt <= r_drain_cnt + 2'd1;
            end else begin
                r_drain_cnt <= '0;
            end
        end
    end

endmodule

### src/plcc_datapath.sv
// Datapath of the polygon limit check and clamp unit: the vertex memory,
// the edge and distance pipeline, the accumulators and the output register.
// Depends on plcc_pkg.
module plcc_datapath import plcc_pkg::*; #(
    parameter int MAX_VERTICES = 64,
    parameter int AW           = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_dp_cmd       i_cmd,
    input  logic [AW-1:0] i_rd_addr,
    input  t_in_word      i_in,
    input  logic          i_out_ready,
    output t_dp_stat      o_stat,
    output logic          o_out_valid,
    output t_out_word     o_out
);

    localparam int DW = C_COORD_W + 1;
    localparam int PW = 2 * DW;

    logic signed [C_COORD_W-1:0] r_mem_x [MAX_VERTICES];
    logic signed [C_COORD_W-1:0] r_mem_y [MAX_VERTICES];

    logic signed [C_COORD_W-1:0] r_tx, r_ty;
    logic signed [C_COORD_W-1:0] r_rd_x, r_rd_y, r_prev_x, r_prev_y;
    logic                        r_s1_valid, r_s1_lead;
    logic [AW-1:0]               r_s1_idx;

    logic signed [DW-1:0]        s1_a, s1_dy, s1_c, s1_d;
    logic signed [PW-1:0]        s1_p1, s1_p2, s1_q1, s1_q2;
    logic                        s1_cross;

    logic                        r_s2_valid, r_s2_cross, r_s2_dypos;
    logic signed [PW-1:0]        r_s2_p1, r_s2_p2, r_s2_q1, r_s2_q2;
    logic [AW-1:0]               r_s2_idx;
    logic signed [C_COORD_W-1:0] r_s2_x, r_s2_y;
    logic                        s2_toggle;
    logic [PW-1:0]               s2_dist;

    logic                        r_s3_valid, r_s3_toggle;
    logic [PW-1:0]               r_s3_dist;
    logic [AW-1:0]               r_s3_idx;
    logic signed [C_COORD_W-1:0] r_s3_x, r_s3_y;

    logic                        r_inside, r_have;
    logic [PW-1:0]               r_best_dist;
    logic [AW-1:0]               r_best_idx;
    logic signed [C_COORD_W-1:0] r_best_x, r_best_y;

    logic                        r_out_valid;
    t_out_word                   r_out;
    logic                        wr_ok;

    assign wr_ok = (int'(i_in.vertex_index) < MAX_VERTICES);

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en && wr_ok) begin
            r_mem_x[AW'(i_in.vertex_index)] <= i_in.coord_x;
            r_mem_y[AW'(i_in.vertex_index)] <= i_in.coord_y;
        end
        if (i_cmd.rd_en) begin
            r_rd_x <= r_mem_x[i_rd_addr];
            r_rd_y <= r_mem_y[i_rd_addr];
        end
    end

    // Edge from the previous vertex j to the current vertex i. The crossing
    // abscissa test is done as an exact cross-multiplication compare.
    assign s1_a     = DW'(r_tx) - DW'(r_rd_x);
    assign s1_dy    = DW'(r_prev_y) - DW'(r_rd_y);
    assign s1_c     = DW'(r_prev_x) - DW'(r_rd_x);
    assign s1_d     = DW'(r_ty) - DW'(r_rd_y);
    assign s1_cross = (r_rd_y > r_ty) != (r_prev_y > r_ty);
    assign s1_p1    = s1_a * s1_dy;
    assign s1_p2    = s1_c * s1_d;
    assign s1_q1    = s1_a * s1_a;
    assign s1_q2    = s1_d * s1_d;

    assign s2_toggle = r_s2_cross && (r_s2_dypos ? (r_s2_p1 < r_s2_p2) : (r_s2_p2 < r_s2_p1));
    assign s2_dist   = r_s2_q1 + r_s2_q2;

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_tx <= i_in.coord_x;
            r_ty <= i_in.coord_y;
        end
        if (i_cmd.rd_en) begin
            r_s1_idx <= i_rd_addr;
        end
        if (r_s1_valid) begin
            r_prev_x <= r_rd_x;
            r_prev_y <= r_rd_y;
        end
        r_s2_cross <= s1_cross;
        r_s2_dypos <= !s1_dy[DW-1];
        r_s2_p1    <= s1_p1;
        r_s2_p2    <= s1_p2;
        r_s2_q1    <= s1_q1;
        r_s2_q2    <= s1_q2;
        r_s2_idx   <= r_s1_idx;
        r_s2_x     <= r_rd_x;
        r_s2_y     <= r_rd_y;
        r_s3_toggle <= s2_toggle;
        r_s3_dist   <= s2_dist;
        r_s3_idx    <= r_s2_idx;
        r_s3_x      <= r_s2_x;
        r_s3_y      <= r_s2_y;
        if (r_s3_valid && (!r_have || (r_s3_dist < r_best_dist))) begin
            r_best_dist <= r_s3_dist;
            r_best_idx  <= r_s3_idx;
            r_best_x    <= r_s3_x;
            r_best_y    <= r_s3_y;
        end
        if (i_cmd.load_out) begin
            r_out.feasible <= r_inside;
            if (r_inside) begin
                r_out.out_x         <= r_tx;
                r_out.out_y         <= r_ty;
                r_out.nearest_index <= '0;
            end else if (r_have) begin
                r_out.out_x         <= r_best_x;
                r_out.out_y         <= r_best_y;
                r_out.nearest_index <= C_INDEX_W'(r_best_idx);
            end else begin
                r_out.out_x         <= '0;
                r_out.out_y         <= '0;
                r_out.nearest_index <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s1_lead   <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_inside    <= 1'b0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_cmd.rd_en;
            r_s1_lead  <= i_cmd.rd_lead;
            // The leading read only primes the previous-vertex register.
            r_s2_valid <= r_s1_valid && !r_s1_lead;
            r_s3_valid <= r_s2_valid;
            if (i_cmd.start) begin
                r_inside <= 1'b0;
                r_have   <= 1'b0;
            end else if (r_s3_valid) begin
                r_inside <= r_inside ^ r_s3_toggle;
                r_have   <= 1'b1;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out           = r_out;

endmodule

### verif/tb_polygon_limit_check_clamp_unit.sv
// Testbench for the polygon limit check and clamp unit: directed stimulus table,
// then random polygons and points, each result checked against a local predictor
// or a hand-typed result. Depends on plcc_pkg and polygon_limit_check_clamp_unit.
`timescale 1ns / 100ps

module tb_polygon_limit_check_clamp_unit;
    import plcc_pkg::*;

    localparam int MAX_VERTS    = 64;
    localparam int RANDOM_WORDS = 800;
    localparam int DRAIN_CYCLES = 80;
    localparam int IDLE_LIMIT   = 5000;

    // One row of the directed table: either a word for the in channel or a new
    // vertex count. A test word may carry an expected result typed in by hand.
    typedef enum logic {ROW_WORD, ROW_COUNT} t_row_kind;

    typedef struct packed {
        t_row_kind            kind;
        t_in_word             word;
        logic                 typed;
        t_out_word            want;
        logic [C_COUNT_W-1:0] count;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    t_in_word             i_in = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out_word            o_out;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [C_COUNT_W-1:0] i_cfg_data = '0;

    // Local copy of the vertex store and of the count register.
    logic signed [C_COORD_W-1:0] vtx_x [MAX_VERTS];
    logic signed [C_COORD_W-1:0] vtx_y [MAX_VERTS];
    logic [C_COUNT_W-1:0]        poly_count = '0;

    t_row      plan_rows [$];
    t_out_word expected_clamps [$];
    t_out_word want_word;

    // Circle picked for the last shape loaded (it bounds a star-shaped one), used to aim test points.
    int box_cx = 0;
    int box_cy = 0;
    int box_r  = 16384;

    bit calm_in  = 1'b0;
    bit calm_out = 1'b0;
    int stall_left = 0;
    int idle_cycles = 0;

    int mismatch_count = 0;
    int word_count = 0;
    int test_count = 0;
    int load_count = 0;
    int count_writes = 0;
    int result_count = 0;
    int inside_count = 0;

    polygon_limit_check_clamp_unit #(
        .MAX_VERTICES(MAX_VERTS)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Even-odd ray test to the right of the point over all edges, then the
    // nearest vertex by squared distance when the point is outside. The
    // crossing test compares cross products instead of dividing; all terms
    // fit comfortably in 64 bits at 16-bit coordinates, so it is exact.
    function automatic t_out_word clamp_point(logic signed [C_COORD_W-1:0] px,
                                              logic signed [C_COORD_W-1:0] py);
        t_out_word r;
        int        n, i, j, best;
        longint    tx, ty, xi, yi, xj, yj, dy, lhs, rhs, d, best_d;
        bit        in_poly;
        n = (int'(poly_count) > MAX_VERTS) ? MAX_VERTS : int'(poly_count);
        tx = px;
        ty = py;
        in_poly = 1'b0;
        r = '0;
        for (i = 0; i < n; i++) begin
            j = (i == 0) ? n - 1 : i - 1;
            xi = vtx_x[i];
            yi = vtx_y[i];
            xj = vtx_x[j];
            yj = vtx_y[j];
            if ((yi > ty) != (yj > ty)) begin
                dy = yj - yi;
                lhs = (tx - xi) * dy;
                rhs = (xj - xi) * (ty - yi);
                if ((dy > 0 && lhs < rhs) || (dy < 0 && lhs > rhs)) begin
                    in_poly = !in_poly;
                end
            end
        end
        if (in_poly) begin
            r.feasible = 1'b1;
            r.out_x = px;
            r.out_y = py;
            return r;
        end
        // Strict less-than keeps the first of several equal distances.
        best = -1;
        best_d = 0;
        for (i = 0; i < n; i++) begin
            xi = vtx_x[i];
            yi = vtx_y[i];
            d = (tx - xi) * (tx - xi) + (ty - yi) * (ty - yi);
            if (best < 0 || d < best_d) begin
                best = i;
                best_d = d;
            end
        end
        if (best >= 0) begin
            r.out_x = vtx_x[best];
            r.out_y = vtx_y[best];
            r.nearest_index = best[C_INDEX_W-1:0];
        end
        return r;
    endfunction

    // Applies an accepted word to the local state and queues its result.
    function automatic void record_word(t_in_word w);
        if (w.func == C_FUNC_LOAD) begin
            vtx_x[w.vertex_index] = w.coord_x;
            vtx_y[w.vertex_index] = w.coord_y;
            load_count++;
        end else begin
            expected_clamps.insert(expected_clamps.size(),
                                   clamp_point(w.coord_x, w.coord_y));
            test_count++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------

    function automatic void add_word(logic func, int idx, int x, int y);
        t_row row;
        row = '0;
        row.kind = ROW_WORD;
        row.word.func = func;
        row.word.vertex_index = C_INDEX_W'(idx);
        row.word.coord_x = C_COORD_W'(x);
        row.word.coord_y = C_COORD_W'(y);
        plan_rows.insert(plan_rows.size(), row);
    endfunction

    function automatic void add_typed(int x, int y, logic feas, int ox, int oy, int oi);
        t_row row;
        row = '0;
        row.kind = ROW_WORD;
        row.word.func = C_FUNC_TEST;
        row.word.coord_x = C_COORD_W'(x);
        row.word.coord_y = C_COORD_W'(y);
        row.typed = 1'b1;
        row.want.feasible = feas;
        row.want.out_x = C_COORD_W'(ox);
        row.want.out_y = C_COORD_W'(oy);
        row.want.nearest_index = C_INDEX_W'(oi);
        plan_rows.insert(plan_rows.size(), row);
    endfunction

    function automatic void add_count(int value);
        t_row row;
        row = '0;
        row.kind = ROW_COUNT;
        row.count = C_COUNT_W'(value);
        plan_rows.insert(plan_rows.size(), row);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic logic signed [C_COORD_W-1:0] fit16(int v);
        if (v > 32767) begin
            v = 32767;
        end else if (v < -32768) begin
            v = -32768;
        end
        return v[C_COORD_W-1:0];
    endfunction

    // Mostly back to back or short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (calm_in) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Holds valid with a fixed word until the block takes it. Valid is left
    // high on return; the next call either replaces the word in the same step
    // or lowers valid for a gap, so valid gets one assignment per step.
    task automatic send_word(input t_in_word w);
        int gap;
        gap = pick_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= w;
        do @(posedge i_clk); while (!o_in_ready);
        word_count++;
    endtask

    // Stops the in channel and waits until every result has come back. The
    // extra cycles cover a trailing load word, which returns nothing.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_clamps.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_vertex_count(input logic [C_COUNT_W-1:0] value);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        poly_count = value;
        count_writes++;
    endtask

    // Star-shaped polygon around a random center: angles rise with the slot
    // number, so the outline never crosses itself. One in five shapes is
    // plain noise over the whole coordinate range instead.
    task automatic load_shape(input int n);
        int       k;
        real      ang, rr;
        bit       noise;
        t_in_word w;
        noise = ($urandom_range(0, 4) == 0);
        box_cx = int'($urandom_range(0, 24000)) - 12000;
        box_cy = int'($urandom_range(0, 24000)) - 12000;
        box_r = ($urandom_range(0, 3) == 0) ? $urandom_range(64, 1000)
                                            : $urandom_range(2000, 16000);
        for (k = 0; k < n; k++) begin
            w = '0;
            w.func = C_FUNC_LOAD;
            w.vertex_index = C_INDEX_W'(k);
            if (noise) begin
                w.coord_x = C_COORD_W'($urandom);
                w.coord_y = C_COORD_W'($urandom);
            end else begin
                ang = 6.283185307 * (k + $urandom_range(0, 80) / 100.0) / n;
                rr = box_r * (0.3 + $urandom_range(0, 70) / 100.0);
                w.coord_x = fit16(box_cx + $rtoi(rr * $cos(ang)));
                w.coord_y = fit16(box_cy + $rtoi(rr * $sin(ang)));
            end
            send_word(w);
            record_word(w);
        end
    endtask

    // Test points: inside the square around the bounding circle, exactly on a vertex, on the
    // midpoint of an edge, level with a vertex (ray through a vertex), or
    // anywhere at all.
    function automatic void pick_point(output logic signed [C_COORD_W-1:0] px,
                                       output logic signed [C_COORD_W-1:0] py);
        int n, k, j, r;
        n = (int'(poly_count) > MAX_VERTS) ? MAX_VERTS : int'(poly_count);
        r = $urandom_range(0, 99);
        px = C_COORD_W'($urandom);
        py = C_COORD_W'($urandom);
        k = (n != 0) ? $urandom_range(0, n - 1) : 0;
        j = (n != 0) ? (k + 1) % n : 0;
        if (r < 35) begin
            px = fit16(box_cx + int'($urandom_range(0, 2 * box_r)) - box_r);
            py = fit16(box_cy + int'($urandom_range(0, 2 * box_r)) - box_r);
        end else if (n != 0 && r < 50) begin
            px = vtx_x[k];
            py = vtx_y[k];
        end else if (n != 0 && r < 60) begin
            px = fit16((int'(vtx_x[k]) + int'(vtx_x[j])) / 2);
            py = fit16((int'(vtx_y[k]) + int'(vtx_y[j])) / 2);
        end else if (n != 0 && r < 75) begin
            py = vtx_y[k];
        end
    endfunction

    // ------------------------------------------------------------------
    // Output side: random stalls, result checking, watchdog
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left--;
        end else if (!calm_out && $urandom_range(0, 99) < 30) begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(1, 3);
        end
        i_out_ready <= (stall_left == 0);
    end

    function automatic void check_field(string name, longint want, longint got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Each result word is matched against the oldest outstanding test.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_clamps.size() == 0) begin
                $display("%0t ns: result word with no test outstanding, got %h",
                         $time, o_out);
                mismatch_count++;
            end else begin
                want_word = expected_clamps.pop_front();
                result_count++;
                if (want_word.feasible) begin
                    inside_count++;
                end
                check_field("feasible", want_word.feasible, o_out.feasible);
                check_field("out_x", $signed(want_word.out_x), $signed(o_out.out_x));
                check_field("out_y", $signed(want_word.out_y), $signed(o_out.out_y));
                check_field("nearest_index", want_word.nearest_index,
                            o_out.nearest_index);
            end
        end
    end

    // Ends a run in which no word has moved on any channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t ns: no word moved for %0d cycles, %0d results outstanding",
                         $time, idle_cycles, expected_clamps.size());
                $display("simulation failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin
        int                   k, r, phase, n_shape, n_tests, start_words;
        logic [C_COUNT_W-1:0] cnt;
        t_in_word             w;
        t_row                 row;

        // The count register resets to zero, so the first tests see an
        // empty polygon.
        add_typed(0, 0, 1'b0, 0, 0, 0);
        add_typed(-32768, 32767, 1'b0, 0, 0, 0);
        // Axis-aligned square at half range, plus the top slot at the extremes.
        add_word(C_FUNC_LOAD, 0, -16384, -16384);
        add_word(C_FUNC_LOAD, 1, 16384, -16384);
        add_word(C_FUNC_LOAD, 2, 16384, 16384);
        add_word(C_FUNC_LOAD, 3, -16384, 16384);
        add_word(C_FUNC_LOAD, 63, 32767, -32768);
        // One and two vertices: parity cannot end up set, so always clamped.
        add_count(1);
        add_typed(32767, 32767, 1'b0, -16384, -16384, 0);
        add_count(2);
        add_typed(20000, -20000, 1'b0, 16384, -16384, 1);
        add_count(4);
        add_typed(0, 0, 1'b1, 0, 0, 0);
        add_typed(-32768, -32768, 1'b0, -16384, -16384, 0);
        add_typed(32767, 32767, 1'b0, 16384, 16384, 2);
        // Equally far from vertices 2 and 3: the lower index wins.
        add_typed(0, 20000, 1'b0, 16384, 16384, 2);
        // Points on a vertex, on each edge of the square and just inside a corner.
        add_word(C_FUNC_TEST, 0, -16384, -16384);
        add_word(C_FUNC_TEST, 0, 0, -16384);
        add_word(C_FUNC_TEST, 63, 16384, 0);
        add_word(C_FUNC_TEST, 0, -16384, 0);
        add_word(C_FUNC_TEST, 0, 0, 16384);
        add_word(C_FUNC_TEST, 0, 16383, 16383);
        // Move one corner to the extreme so the polygon is no longer a square.
        add_word(C_FUNC_LOAD, 2, 32767, 32767);
        add_word(C_FUNC_TEST, 0, 32767, 0);
        add_count(3);
        add_word(C_FUNC_TEST, 0, 8000, -8000);
        add_word(C_FUNC_TEST, 0, -8000, 8000);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan_rows[k]) begin
            row = plan_rows[k];
            if (row.kind == ROW_COUNT) begin
                set_vertex_count(row.count);
            end else begin
                send_word(row.word);
                if (row.typed) begin
                    expected_clamps.insert(expected_clamps.size(), row.want);
                    test_count++;
                end else begin
                    record_word(row.word);
                end
            end
        end

        // Random part. Every slot is written first, so any count, including
        // those above the store size, only reads written vertices.
        start_words = word_count;
        for (k = 0; k < MAX_VERTS; k++) begin
            w = '0;
            w.func = C_FUNC_LOAD;
            w.vertex_index = C_INDEX_W'(k);
            w.coord_x = C_COORD_W'($urandom);
            w.coord_y = C_COORD_W'($urandom);
            send_word(w);
            record_word(w);
        end

        phase = 0;
        while (word_count - start_words < RANDOM_WORDS) begin
            calm_in = ($urandom_range(0, 4) == 0);
            calm_out = ($urandom_range(0, 4) == 0);

            // Mostly small polygons; the full store now and then.
            r = $urandom_range(0, 99);
            if (r < 50) begin
                n_shape = $urandom_range(3, 8);
            end else if (r < 80) begin
                n_shape = $urandom_range(9, 24);
            end else if (r < 92) begin
                n_shape = $urandom_range(25, 63);
            end else begin
                n_shape = MAX_VERTS;
            end
            r = $urandom_range(0, 99);
            if (r < 4) begin
                cnt = C_COUNT_W'(0);
            end else if (r < 8) begin
                cnt = C_COUNT_W'(1);
            end else if (r < 12) begin
                cnt = C_COUNT_W'(2);
            end else if (r < 15) begin
                cnt = C_COUNT_W'(65);
            end else if (r < 18) begin
                cnt = C_COUNT_W'(127);
            end else begin
                cnt = C_COUNT_W'(n_shape);
            end
            // The first phases pin the register extremes.
            if (phase == 0) begin
                n_shape = MAX_VERTS;
                cnt = C_COUNT_W'(MAX_VERTS);
            end else if (phase == 1) begin
                cnt = C_COUNT_W'(127);
            end else if (phase == 2) begin
                cnt = C_COUNT_W'(0);
            end

            if (phase == 0 || $urandom_range(0, 9) != 0) begin
                load_shape(n_shape);
            end
            set_vertex_count(cnt);

            // Mostly tests against the loaded shape, with stray vertex writes
            // that bend it.
            n_tests = $urandom_range(8, 30);
            for (k = 0; k < n_tests; k++) begin
                w = '0;
                if ($urandom_range(0, 99) < 12) begin
                    w.func = C_FUNC_LOAD;
                    w.vertex_index = C_INDEX_W'($urandom_range(0, MAX_VERTS - 1));
                    w.coord_x = C_COORD_W'($urandom);
                    w.coord_y = C_COORD_W'($urandom);
                end else begin
                    w.func = C_FUNC_TEST;
                    w.vertex_index = C_INDEX_W'($urandom);
                    pick_point(w.coord_x, w.coord_y);
                end
                send_word(w);
                record_word(w);
            end
            phase++;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run covered %0d words: %0d point tests, %0d vertex loads, %0d count settings",
                 word_count, test_count, load_count, count_writes);
        $display("%0d results compared, %0d inside the polygon, %0d clamped or empty",
                 result_count, inside_count, result_count - inside_count);
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
